### rtl/assert_macros.svh
// Assertion macros shared by the marquee RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Clocked property check, disabled while reset is low.
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("marquee assertion failed");
// Expression that must never be true at a clock edge.
`define ASSERT_NEVER(lbl, expr) \
  `ASSERT_CLK(lbl, !(expr))
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_NEVER(lbl, expr)
`endif

`endif

### rtl/stm_pkg.sv
// Types and constants shared by the marquee controller and datapath.
package stm_pkg;

  localparam logic [7:0] CR_CODE    = 8'h0d;
  localparam logic [7:0] SPACE_CODE = 8'h20;
  localparam logic [7:0] NUL_CODE   = 8'h00;
  localparam int unsigned BLANK_LEN = 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BLANK,
    ST_SHOW
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic wr_char;    // store typed character
    logic cr;         // take typed text as show text
    logic clr_cnt;    // restart the word counter
    logic load_blank; // load a space into the output register
    logic load_show;  // load a show character into the output register
    logic rotate;     // rotate show text left by one
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic scroll;     // a carriage return has been seen
    logic out_free;   // output register can take a word this cycle
    logic blank_end;  // current blank word is the last one
    logic show_end;   // current show word is the last one
  } sts_t;

endpackage

### rtl/scrolling_text_marquee_top.sv
// Scrolling text marquee: a typed character is stored in the typing bank.
// A carriage return swaps the banks, then 8 blank words follow at one per
// cycle unless the output stalls. A tick shows each character (up to
// MAX_CHARS), paced by the single read port of the text buffer; the output
// register lets the next item enter while the final word waits.
// Reset clears control state only; text buffers hold no reset value.
module scrolling_text_marquee_top #(
  parameter int MAX_CHARS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [7:0] char_in
  input  logic       s_axis_tuser,  // [0] kind
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,  // [7:0] char_out
  output logic       m_axis_tlast,
  output logic       m_axis_tuser   // [0] empty_res
);
  import stm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  stm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_kind_i  (s_axis_tuser),
    .s_char_i  (s_axis_tdata),
    .s_ready_o (s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  stm_dp #(
    .MAX_CHARS (MAX_CHARS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .char_i    (s_axis_tdata),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_char_o  (m_axis_tdata),
    .m_last_o  (m_axis_tlast),
    .m_empty_o (m_axis_tuser)
  );

  // Checks
  logic cr_acc;
  logic empty_ok;

  assign cr_acc   = s_axis_tvalid && s_axis_tready && !s_axis_tuser &&
                    (s_axis_tdata == CR_CODE);
  assign empty_ok = m_axis_tlast && (m_axis_tdata == NUL_CODE);

`include "assert_macros.svh"

  `ASSERT_CLK(a_empty_is_last, m_axis_tvalid && m_axis_tuser |-> empty_ok)
  `ASSERT_CLK(a_cr_busy, cr_acc |=> !s_axis_tready)
  `ASSERT_NEVER(a_one_load, cmd.load_blank && cmd.load_show)

endmodule

### rtl/stm_ctrl.sv
// Controller state machine of the marquee: item decode and word sequencing.
module stm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_valid_i,
  input  logic          s_kind_i,
  input  logic [7:0]    s_char_i,
  output logic          s_ready_o,
  input  stm_pkg::sts_t sts_i,
  output stm_pkg::cmd_t cmd_o
);
  import stm_pkg::*;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          if (!s_kind_i) begin
            if (s_char_i == CR_CODE) begin
              cmd_o.cr      = 1'b1;
              cmd_o.clr_cnt = 1'b1;
              state_d       = ST_BLANK;
            end else begin
              cmd_o.wr_char = 1'b1;
            end
          end else if (sts_i.scroll) begin
            cmd_o.clr_cnt = 1'b1;
            state_d       = ST_SHOW;
          end
        end
      end
      ST_BLANK: begin
        if (sts_i.out_free) begin
          cmd_o.load_blank = 1'b1;
          if (sts_i.blank_end) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_SHOW: begin
        if (sts_i.out_free) begin
          cmd_o.load_show = 1'b1;
          if (sts_i.show_end) begin
            cmd_o.rotate = 1'b1;
            state_d      = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/stm_dp.sv
// Datapath of the marquee: text buffers, counters and output word register.
module stm_dp #(
  parameter int MAX_CHARS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  stm_pkg::cmd_t cmd_i,
  output stm_pkg::sts_t sts_o,
  input  logic [7:0]    char_i,
  output logic          m_valid_o,
  input  logic          m_ready_i,
  output logic [7:0]    m_char_o,
  output logic          m_last_o,
  output logic          m_empty_o
);
  import stm_pkg::*;

  localparam int IW    = $clog2(MAX_CHARS);
  localparam int LW    = $clog2(MAX_CHARS + 1);
  localparam int CW    = (LW > 3) ? LW : 3;
  localparam int AW    = IW + 1;
  localparam int DEPTH = 2 ** AW;

  // Two banks: one holds the show text, the other takes typing
  logic [7:0] mem [DEPTH];

  logic          bank_q;
  logic [LW-1:0] typed_cnt_q;
  logic          zero_seen_q;
  logic [LW-1:0] zero_pos_q;
  logic [LW-1:0] show_len_q;
  logic [LW-1:0] rot_q;
  logic          scroll_q;
  logic [CW-1:0] cnt_q;
  logic          out_valid_q;
  logic [7:0]    out_char_q;
  logic          out_last_q;
  logic          out_empty_q;

  logic          typed_full;
  logic [LW-1:0] wr_pos;
  logic [AW-1:0] wr_addr;
  logic [LW:0]   rd_sum;
  logic [LW:0]   rd_wrap;
  logic [AW-1:0] rd_addr;
  logic          show_empty;
  logic          show_last;
  logic [LW:0]   rot_inc;
  logic          load;

  assign typed_full = (typed_cnt_q == LW'(MAX_CHARS));
  assign wr_pos     = typed_full ? '0 : typed_cnt_q;
  assign wr_addr    = {~bank_q, wr_pos[IW-1:0]};

  // Rotated read index: (rot + cnt) mod len, both below len
  assign rd_sum  = {1'b0, rot_q} + (LW+1)'(cnt_q);
  assign rd_wrap = (rd_sum >= {1'b0, show_len_q}) ? (rd_sum - {1'b0, show_len_q}) : rd_sum;
  assign rd_addr = {bank_q, rd_wrap[IW-1:0]};

  assign show_empty = (show_len_q == '0);
  assign show_last  = show_empty ||
                      (({1'b0, cnt_q} + (CW+1)'(1)) == (CW+1)'(show_len_q));
  assign rot_inc    = {1'b0, rot_q} + (LW+1)'(1);
  assign load       = cmd_i.load_blank | cmd_i.load_show;

  assign sts_o.scroll    = scroll_q;
  assign sts_o.out_free  = !out_valid_q || m_ready_i;
  assign sts_o.blank_end = (cnt_q == CW'(BLANK_LEN - 1));
  assign sts_o.show_end  = show_last;

  // Typing, show text and rotation state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q      <= 1'b0;
      typed_cnt_q <= '0;
      zero_seen_q <= 1'b0;
      zero_pos_q  <= '0;
      show_len_q  <= '0;
      rot_q       <= '0;
      scroll_q    <= 1'b0;
    end else begin
      if (cmd_i.wr_char) begin
        typed_cnt_q <= wr_pos + LW'(1);
        if ((char_i == NUL_CODE) && (!zero_seen_q || typed_full)) begin
          zero_seen_q <= 1'b1;
          zero_pos_q  <= wr_pos;
        end else if (typed_full) begin
          zero_seen_q <= 1'b0;
        end
      end
      if (cmd_i.cr) begin
        show_len_q  <= zero_seen_q ? zero_pos_q : typed_cnt_q;
        typed_cnt_q <= '0;
        zero_seen_q <= 1'b0;
        bank_q      <= ~bank_q;
        rot_q       <= '0;
        scroll_q    <= 1'b1;
      end
      if (cmd_i.rotate && (show_len_q > LW'(1))) begin
        rot_q <= (rot_inc == {1'b0, show_len_q}) ? '0 : rot_inc[LW-1:0];
      end
    end
  end

  // Word counter within one message
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.clr_cnt) begin
      cnt_q <= '0;
    end else if (load) begin
      cnt_q <= cnt_q + CW'(1);
    end
  end

  // Buffer write port
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_char) begin
      mem[wr_addr] <= char_i;
    end
  end

  // Output register doubles as the buffer read data register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_blank) begin
      out_char_q  <= SPACE_CODE;
      out_last_q  <= sts_o.blank_end;
      out_empty_q <= 1'b0;
    end else if (cmd_i.load_show) begin
      out_char_q  <= show_empty ? NUL_CODE : mem[rd_addr];
      out_last_q  <= show_last;
      out_empty_q <= show_empty;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_char_o  = out_char_q;
  assign m_last_o  = out_last_q;
  assign m_empty_o = out_empty_q;

endmodule
